@@ design/particle_pool_update_top_macros.svh @@
// Assertion macros for the particle pool checker.
`ifndef PARTICLE_POOL_UPDATE_TOP_MACROS_SVH
`define PARTICLE_POOL_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("particle pool check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("particle pool check failed");

`endif

@@ design/ppu_pkg.sv @@
// Types, constants and helpers of the particle pool.
package ppu_pkg;

  localparam logic [1:0] MODE_SPAWN = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_KILL1 = 2'd2;
  localparam logic [1:0] MODE_KALL  = 2'd3;

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_ALPHA = 1'b1;

  localparam int unsigned DT_MAX     = 205;
  localparam int unsigned LIMIT_MIN  = 64;
  localparam int unsigned ALPHA_ONE  = 256;
  localparam int unsigned DIV_LANES  = 5;
  localparam int unsigned DIV_STEPS  = 16;
  localparam logic signed [12:0] GRAV_Q8 = -13'sd2509;
  localparam logic signed [23:0] FLOOR_Y = -24'sd128000;
  localparam logic [15:0] RECIP5     = 16'd52429;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [15:0]        lifetime;
    logic [15:0]        start_size;
    logic [31:0]        colour;
    logic [15:0]        time_step;
    logic [7:0]         slot;
  } ppu_in_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] slot_used;
    logic [8:0] active_count;
  } ppu_out_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic [15:0]        tot;
    logic [15:0]        size;
    logic [15:0]        size_end;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [7:0]         red_end;
    logic [7:0]         green_end;
  } ppu_rec_t;

  typedef enum logic [4:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SP_RD,
    ST_SP_CHK,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_MUL,
    ST_TK_POS,
    ST_TK_YCHK,
    ST_TK_SMUL,
    ST_TK_SUM,
    ST_TK_DIVGO,
    ST_TK_DIV,
    ST_TK_WB,
    ST_TK_END,
    ST_KALL,
    ST_DONE
  } ppu_state_e;

  typedef struct packed {
    logic in_ready;
    logic addr_clr;
    logic addr_inc;
    logic rd;
    logic life_zero_wr;
    logic use_slot;
    logic spawn_wr;
    logic gdt_load;
    logic age;
    logic mul;
    logic pos;
    logic smul;
    logic sum;
    logic div_go;
    logic wb;
    logic wb_shape;
    logic cnt_clr;
    logic cnt_inc;
    logic live_from_cnt;
    logic live_clr;
    logic out_load;
  } ppu_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       addr_last;
    logic       below_limit;
    logic       life_zero;
    logic       life_le_dt;
    logic       y_dead;
    logic       tot_zero;
    logic       slot_ok;
    logic       div_busy;
    logic       out_free;
  } ppu_sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] x);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sd8388607;
    lo = -26'sd8388608;
    if (x > hi) return 24'sh7FFFFF;
    if (x < lo) return 24'sh800000;
    return x[23:0];
  endfunction

endpackage

@@ design/ppu_div.sv @@
// Five-lane restoring divider sharing one denominator, one quotient bit per cycle.
module ppu_div (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [ppu_pkg::DIV_LANES-1:0][31:0]      num_i,
  input  logic [15:0]                              den_i,
  output logic                                     busy_o,
  output logic [ppu_pkg::DIV_LANES-1:0][15:0]      quo_o
);

  logic [4:0]                                 cnt_q, cnt_d;
  logic                                       busy_q, busy_d;
  logic [15:0]                                den_q;
  logic [ppu_pkg::DIV_LANES-1:0][15:0]        rem_q;
  logic [ppu_pkg::DIV_LANES-1:0][15:0]        low_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'(ppu_pkg::DIV_STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // The upper half of every numerator is below the denominator.
  for (genvar l = 0; l < ppu_pkg::DIV_LANES; l++) begin : g_lane
    logic [16:0] trial;
    logic        fits;
    assign trial = {rem_q[l], low_q[l][15]};
    assign fits  = trial >= {1'b0, den_q};
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q[l] <= num_i[l][31:16];
        low_q[l] <= num_i[l][15:0];
      end else if (busy_q) begin
        rem_q[l] <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        low_q[l] <= {low_q[l][14:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quo_o  = low_q;

endmodule

@@ design/ppu_ctrl.sv @@
// Sequencer for spawn, tick, kill and clearing sweeps.
module ppu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ppu_pkg::ppu_sts_t sts_i,
  output ppu_pkg::ppu_cmd_t cmd_o
);

  ppu_pkg::ppu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ppu_pkg::ST_RST_CLR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppu_pkg::ST_RST_CLR: if (sts_i.addr_last) state_d = ppu_pkg::ST_IDLE;
      ppu_pkg::ST_IDLE:    if (in_valid_i) state_d = ppu_pkg::ST_DISPATCH;
      ppu_pkg::ST_DISPATCH: begin
        unique case (sts_i.mode)
          ppu_pkg::MODE_SPAWN:
            state_d = sts_i.below_limit ? ppu_pkg::ST_SP_RD : ppu_pkg::ST_DONE;
          ppu_pkg::MODE_TICK:  state_d = ppu_pkg::ST_TK_RD;
          ppu_pkg::MODE_KILL1: state_d = ppu_pkg::ST_DONE;
          default:             state_d = ppu_pkg::ST_KALL;
        endcase
      end
      ppu_pkg::ST_SP_RD: state_d = ppu_pkg::ST_SP_CHK;
      ppu_pkg::ST_SP_CHK: begin
        if (sts_i.life_zero || sts_i.addr_last) state_d = ppu_pkg::ST_DONE;
        else                                    state_d = ppu_pkg::ST_SP_RD;
      end
      ppu_pkg::ST_TK_RD: state_d = ppu_pkg::ST_TK_CHK;
      ppu_pkg::ST_TK_CHK: begin
        if (sts_i.life_zero || sts_i.life_le_dt)
          state_d = sts_i.addr_last ? ppu_pkg::ST_TK_END : ppu_pkg::ST_TK_RD;
        else
          state_d = ppu_pkg::ST_TK_MUL;
      end
      ppu_pkg::ST_TK_MUL: state_d = ppu_pkg::ST_TK_POS;
      ppu_pkg::ST_TK_POS: state_d = ppu_pkg::ST_TK_YCHK;
      ppu_pkg::ST_TK_YCHK: begin
        if (sts_i.y_dead || sts_i.tot_zero)
          state_d = sts_i.addr_last ? ppu_pkg::ST_TK_END : ppu_pkg::ST_TK_RD;
        else
          state_d = ppu_pkg::ST_TK_SMUL;
      end
      ppu_pkg::ST_TK_SMUL:  state_d = ppu_pkg::ST_TK_SUM;
      ppu_pkg::ST_TK_SUM:   state_d = ppu_pkg::ST_TK_DIVGO;
      ppu_pkg::ST_TK_DIVGO: state_d = ppu_pkg::ST_TK_DIV;
      ppu_pkg::ST_TK_DIV:   if (!sts_i.div_busy) state_d = ppu_pkg::ST_TK_WB;
      ppu_pkg::ST_TK_WB:
        state_d = sts_i.addr_last ? ppu_pkg::ST_TK_END : ppu_pkg::ST_TK_RD;
      ppu_pkg::ST_TK_END: state_d = ppu_pkg::ST_DONE;
      ppu_pkg::ST_KALL:   if (sts_i.addr_last) state_d = ppu_pkg::ST_DONE;
      ppu_pkg::ST_DONE:   if (sts_i.out_free) state_d = ppu_pkg::ST_IDLE;
      default:            state_d = ppu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ppu_pkg::ST_RST_CLR, ppu_pkg::ST_KALL: begin
        cmd_o.life_zero_wr = 1'b1;
        cmd_o.addr_inc     = !sts_i.addr_last;
      end
      ppu_pkg::ST_IDLE: cmd_o.in_ready = 1'b1;
      ppu_pkg::ST_DISPATCH: begin
        cmd_o.addr_clr = 1'b1;
        unique case (sts_i.mode)
          ppu_pkg::MODE_SPAWN: ;
          ppu_pkg::MODE_TICK: begin
            cmd_o.gdt_load = 1'b1;
            cmd_o.cnt_clr  = 1'b1;
          end
          ppu_pkg::MODE_KILL1: begin
            cmd_o.life_zero_wr = sts_i.slot_ok;
            cmd_o.use_slot     = 1'b1;
          end
          default: cmd_o.live_clr = 1'b1;
        endcase
      end
      ppu_pkg::ST_SP_RD: cmd_o.rd = 1'b1;
      ppu_pkg::ST_SP_CHK: begin
        cmd_o.spawn_wr = sts_i.life_zero;
        cmd_o.addr_inc = !sts_i.life_zero && !sts_i.addr_last;
      end
      ppu_pkg::ST_TK_RD: cmd_o.rd = 1'b1;
      ppu_pkg::ST_TK_CHK: begin
        cmd_o.cnt_inc = !sts_i.life_zero;
        if (sts_i.life_zero || sts_i.life_le_dt) begin
          cmd_o.life_zero_wr = !sts_i.life_zero;
          cmd_o.addr_inc     = !sts_i.addr_last;
        end else begin
          cmd_o.age = 1'b1;
        end
      end
      ppu_pkg::ST_TK_MUL: cmd_o.mul = 1'b1;
      ppu_pkg::ST_TK_POS: cmd_o.pos = 1'b1;
      ppu_pkg::ST_TK_YCHK: begin
        if (sts_i.y_dead) begin
          cmd_o.life_zero_wr = 1'b1;
          cmd_o.addr_inc     = !sts_i.addr_last;
        end else if (sts_i.tot_zero) begin
          cmd_o.wb       = 1'b1;
          cmd_o.addr_inc = !sts_i.addr_last;
        end else begin
          cmd_o.smul = 1'b1;
        end
      end
      ppu_pkg::ST_TK_SMUL:  cmd_o.sum = 1'b1;
      ppu_pkg::ST_TK_SUM:   cmd_o.div_go = 1'b1;
      ppu_pkg::ST_TK_DIVGO: ;
      ppu_pkg::ST_TK_DIV:   ;
      ppu_pkg::ST_TK_WB: begin
        cmd_o.wb       = 1'b1;
        cmd_o.wb_shape = 1'b1;
        cmd_o.addr_inc = !sts_i.addr_last;
      end
      ppu_pkg::ST_TK_END: cmd_o.live_from_cnt = 1'b1;
      ppu_pkg::ST_DONE:   cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/ppu_dp.sv @@
// Slot memories, tick arithmetic, counters, config and result register.
module ppu_dp #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppu_pkg::ppu_cmd_t   cmd_i,
  output ppu_pkg::ppu_sts_t   sts_o,
  input  logic                in_valid_i,
  input  ppu_pkg::ppu_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ppu_pkg::ppu_out_t   out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [8:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;
  localparam int unsigned SW = (AW > 8) ? AW : 8;

  logic [15:0]        life_mem [POOL_SIZE];
  ppu_pkg::ppu_rec_t  rec_mem  [POOL_SIZE];

  ppu_pkg::ppu_in_t   item_q;
  logic [AW-1:0]      addr_q;
  logic [15:0]        rd_life_q;
  ppu_pkg::ppu_rec_t  rd_rec_q;
  ppu_pkg::ppu_rec_t  w_q;
  logic [15:0]        life_n_q;
  logic [7:0]         dt_q;
  logic signed [9:0]  gdt_q;
  logic signed [32:0] px_q, py_q, pz_q;
  logic [31:0]        msa_q, msb_q;
  logic [23:0]        mra_q, mrb_q, mga_q, mgb_q, mb_q, ma_q;
  logic [ppu_pkg::DIV_LANES-1:0][31:0] num_q;
  logic [ppu_pkg::DIV_LANES-1:0][15:0] quo;
  logic               div_busy;
  logic [CW-1:0]      live_q, cnt_q, limit_q;
  logic [8:0]         alpha_q;
  logic               res_acc_q;
  logic [7:0]         res_slot_q;
  logic               out_valid_q;
  ppu_pkg::ppu_out_t  out_q;

  logic [7:0]         dt_c;
  logic signed [21:0] gprod;
  logic [31:0]        end_prod;
  logic [SW-1:0]      slot_ext, addr_ext;
  logic [AW-1:0]      life_waddr;
  logic               life_we;
  logic [15:0]        life_wdata;
  logic               rec_we;
  ppu_pkg::ppu_rec_t  rec_wdata, spawn_rec, shaped;
  ppu_pkg::ppu_rec_t  aged, moved;
  logic [15:0]        life_c, elapsed;
  logic [32:0]        alpha_prod;
  logic [LW-1:0]      cfg_ext;
  logic [LW-1:0]      live_ext;
  logic               item_load;

  assign item_load = in_valid_i && cmd_i.in_ready;
  assign slot_ext  = SW'(item_q.slot);
  assign addr_ext  = SW'(addr_q);

  always_ff @(posedge clk_i) begin
    if (item_load) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           addr_q <= '0;
    else if (cmd_i.addr_clr) addr_q <= '0;
    else if (cmd_i.addr_inc) addr_q <= addr_q + 1'b1;
  end

  // Spawn record, end size by reciprocal multiply
  assign end_prod = 32'(item_q.start_size * ppu_pkg::RECIP5);
  always_comb begin
    spawn_rec           = '0;
    spawn_rec.pos_x     = item_q.pos_x;
    spawn_rec.pos_y     = item_q.pos_y;
    spawn_rec.pos_z     = item_q.pos_z;
    spawn_rec.vel_x     = item_q.vel_x;
    spawn_rec.vel_y     = item_q.vel_y;
    spawn_rec.vel_z     = item_q.vel_z;
    spawn_rec.tot       = item_q.lifetime;
    spawn_rec.size      = item_q.start_size;
    spawn_rec.size_end  = {2'b00, end_prod[31:18]};
    spawn_rec.red       = item_q.colour[31:24];
    spawn_rec.green     = item_q.colour[23:16];
    spawn_rec.blue      = item_q.colour[15:8];
    spawn_rec.alpha     = item_q.colour[7:0];
    spawn_rec.red_end   = item_q.colour[31:24];
    spawn_rec.green_end = {1'b0, item_q.colour[23:17]};
  end

  always_comb begin
    shaped       = w_q;
    shaped.size  = quo[0];
    shaped.red   = quo[1][7:0];
    shaped.green = quo[2][7:0];
    shaped.blue  = quo[3][7:0];
    shaped.alpha = quo[4][7:0];
  end

  always_comb begin
    life_we    = cmd_i.spawn_wr || cmd_i.wb || cmd_i.life_zero_wr;
    life_waddr = cmd_i.use_slot ? slot_ext[AW-1:0] : addr_q;
    if (cmd_i.spawn_wr)  life_wdata = item_q.lifetime;
    else if (cmd_i.wb)   life_wdata = life_n_q;
    else                 life_wdata = '0;
    rec_we    = cmd_i.spawn_wr || cmd_i.wb;
    if (cmd_i.spawn_wr)      rec_wdata = spawn_rec;
    else if (cmd_i.wb_shape) rec_wdata = shaped;
    else                     rec_wdata = w_q;
  end

  always_ff @(posedge clk_i) begin
    if (life_we) life_mem[life_waddr] <= life_wdata;
    if (cmd_i.rd) rd_life_q <= life_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[addr_q] <= rec_wdata;
    if (cmd_i.rd) rd_rec_q <= rec_mem[addr_q];
  end

  // Step clamp and gravity increment, fixed for the whole tick
  assign dt_c  = (item_q.time_step > 16'(ppu_pkg::DT_MAX)) ? 8'(ppu_pkg::DT_MAX)
                                                          : item_q.time_step[7:0];
  assign gprod = 22'(ppu_pkg::GRAV_Q8 * $signed({1'b0, dt_c}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.gdt_load) begin
      dt_q  <= dt_c;
      gdt_q <= gprod[21:12];
    end
  end

  // Age, gravity and position integration
  always_comb begin
    aged       = rd_rec_q;
    aged.vel_y = ppu_pkg::sat24({{2{rd_rec_q.vel_y[23]}}, rd_rec_q.vel_y} +
                                {{16{gdt_q[9]}}, gdt_q});
  end

  always_comb begin
    moved       = w_q;
    moved.pos_x = ppu_pkg::sat24({{2{w_q.pos_x[23]}}, w_q.pos_x} +
                                 {{5{px_q[32]}}, px_q[32:12]});
    moved.pos_y = ppu_pkg::sat24({{2{w_q.pos_y[23]}}, w_q.pos_y} +
                                 {{5{py_q[32]}}, py_q[32:12]});
    moved.pos_z = ppu_pkg::sat24({{2{w_q.pos_z[23]}}, w_q.pos_z} +
                                 {{5{pz_q[32]}}, pz_q[32:12]});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.age) begin
      w_q      <= aged;
      life_n_q <= rd_life_q - {8'd0, dt_q};
    end else if (cmd_i.pos) begin
      w_q <= moved;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      px_q <= $signed(w_q.vel_x) * $signed({1'b0, dt_q});
      py_q <= $signed(w_q.vel_y) * $signed({1'b0, dt_q});
      pz_q <= $signed(w_q.vel_z) * $signed({1'b0, dt_q});
    end
  end

  // Blend weights: remaining and elapsed life
  assign life_c  = (life_n_q <= w_q.tot) ? life_n_q : w_q.tot;
  assign elapsed = (life_n_q <= w_q.tot) ? 16'(w_q.tot - life_n_q) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.smul) begin
      msa_q <= 32'(w_q.size * life_c);
      msb_q <= 32'(w_q.size_end * elapsed);
      mra_q <= 24'(w_q.red * life_c);
      mrb_q <= 24'(w_q.red_end * elapsed);
      mga_q <= 24'(w_q.green * life_c);
      mgb_q <= 24'(w_q.green_end * elapsed);
      mb_q  <= 24'(w_q.blue * life_c);
      ma_q  <= 24'(w_q.alpha * life_c);
    end
  end

  assign alpha_prod = 33'(ma_q * alpha_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      num_q[0] <= msa_q + msb_q;
      num_q[1] <= 32'(mra_q) + 32'(mrb_q);
      num_q[2] <= 32'(mga_q) + 32'(mgb_q);
      num_q[3] <= 32'(mb_q);
      num_q[4] <= 32'(alpha_prod[32:8]);
    end
  end

  ppu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (num_q),
    .den_i  (w_q.tot),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  // Counters and configuration
  assign cfg_ext = LW'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CW'(POOL_SIZE);
      alpha_q <= 9'(ppu_pkg::ALPHA_ONE);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ppu_pkg::CFG_LIMIT) begin
        if (cfg_ext > LW'(POOL_SIZE))               limit_q <= CW'(POOL_SIZE);
        else if (cfg_ext < LW'(ppu_pkg::LIMIT_MIN)) limit_q <= CW'(ppu_pkg::LIMIT_MIN);
        else                                        limit_q <= cfg_ext[CW-1:0];
      end else begin
        alpha_q <= (cfg_data_i > 9'(ppu_pkg::ALPHA_ONE)) ? 9'(ppu_pkg::ALPHA_ONE)
                                                         : cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q     <= '0;
      cnt_q      <= '0;
      res_acc_q  <= 1'b0;
      res_slot_q <= '0;
    end else begin
      if (cmd_i.cnt_clr)      cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.live_clr)           live_q <= '0;
      else if (cmd_i.live_from_cnt) live_q <= cnt_q;
      else if (cmd_i.spawn_wr)      live_q <= live_q + 1'b1;
      if (item_load) begin
        res_acc_q  <= 1'b0;
        res_slot_q <= '0;
      end else if (cmd_i.spawn_wr) begin
        res_acc_q  <= 1'b1;
        res_slot_q <= addr_ext[7:0];
      end
    end
  end

  // Result register
  assign live_ext = LW'(live_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.accepted     <= res_acc_q;
      out_q.slot_used    <= res_slot_q;
      out_q.active_count <= live_ext[8:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.mode        = item_q.mode;
  assign sts_o.addr_last   = addr_q == AW'(POOL_SIZE - 1);
  assign sts_o.below_limit = live_q < limit_q;
  assign sts_o.life_zero   = rd_life_q == '0;
  assign sts_o.life_le_dt  = rd_life_q <= {8'd0, dt_q};
  assign sts_o.y_dead      = $signed(w_q.pos_y) < ppu_pkg::FLOOR_Y;
  assign sts_o.tot_zero    = w_q.tot == '0;
  assign sts_o.slot_ok     = 32'(slot_ext) < POOL_SIZE;
  assign sts_o.div_busy    = div_busy;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

@@ design/particle_pool_update_top.sv @@
// Particle pool: spawn, tick, kill one and kill all over POOL_SIZE slots.
// Spawn: scans the slots in order for the first free one.
// Tick: per slot, free slots are skipped, expiring or fallen ones are freed, the rest aged and moved.
// Kill one clears a single slot; kill all sweeps the life memory.
// One item at a time; the next is taken while a result waits in the output register.
// After reset the life memory is swept clear before the first item is taken.
module particle_pool_update_top #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppu_pkg::ppu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ppu_pkg::ppu_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [8:0]        cfg_data_i
);

  ppu_pkg::ppu_cmd_t cmd;
  ppu_pkg::ppu_sts_t sts;

  ppu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ppu_dp #(
    .POOL_SIZE(POOL_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  assign in_ready_o = cmd.in_ready;

endmodule

@@ design/ppu_checker.sv @@
// Port-level checker for the particle pool, bound to the top level.
`include "particle_pool_update_top_macros.svh"

module ppu_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ppu_pkg::ppu_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ppu_pkg::ppu_out_t out_data_o,
  input logic              cfg_we_i,
  input logic              cfg_idx_i,
  input logic [8:0]        cfg_data_i
);

  // hold a stalled result
  `PPU_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // a refused or non-spawn item reports slot zero
  `PPU_ASSERT_IMP(a_slot_zero, out_valid_o && !out_data_o.accepted, out_data_o.slot_used == 8'd0)

  // one item in flight: ready drops right after an accept
  `PPU_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind particle_pool_update_top ppu_checker u_ppu_checker (.*);

@@ test/particle_pool_update_top_tb.sv @@
// Testbench for the particle pool: directed table, then random bursts against a predictor.
module particle_pool_update_top_tb;

  localparam int unsigned POOL = 256;
  localparam int unsigned STALL_LIMIT = 40000;

  typedef struct {
    ppu_pkg::ppu_in_t  item;
    bit                typed;
    ppu_pkg::ppu_out_t res;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ppu_pkg::ppu_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ppu_pkg::ppu_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic     cfg_idx_i = ppu_pkg::CFG_LIMIT;
  logic [8:0] cfg_data_i = '0;

  // Pool shadow
  int          pos_q8 [POOL][3];
  int          vel_q8 [POOL][3];
  int unsigned life_q12 [POOL];
  int unsigned tot_q12 [POOL];
  int unsigned size_cur [POOL];
  int unsigned size_end [POOL];
  int unsigned rgba [POOL][6];
  int unsigned live_n;
  int unsigned limit_reg;
  int unsigned alpha_reg;

  ppu_pkg::ppu_out_t pending_res[$];
  bit       typed_q[$];
  ppu_pkg::ppu_out_t typed_res_q[$];
  int       errors = 0;
  int       n_items = 0;
  int       n_results = 0;
  int       n_spawned = 0;
  int       n_refused = 0;
  int       n_ticks = 0;
  int       idle_cycles = 0;
  bit       rx_smooth = 1'b0;

  particle_pool_update_top u_top (.*);

  always #1 clk_i = ~clk_i;

  function automatic int sat_q8(longint x);
    if (x > 64'sd8388607) return 8388607;
    if (x < -64'sd8388608) return -8388608;
    return int'(x);
  endfunction

  function automatic void pool_clear();
    for (int i = 0; i < POOL; i++) life_q12[i] = 0;
    live_n = 0;
    limit_reg = POOL;
    alpha_reg = ppu_pkg::ALPHA_ONE;
  endfunction

  function automatic void age_particle(int i, int unsigned dt);
    longint unsigned lf;
    longint unsigned tt;
    longint unsigned el;
    if (life_q12[i] <= dt) begin
      life_q12[i] = 0;
      return;
    end
    life_q12[i] -= dt;
    vel_q8[i][1] = sat_q8(longint'(vel_q8[i][1]) +
                          ((longint'(-2509) * longint'(dt)) >>> 12));
    for (int k = 0; k < 3; k++)
      pos_q8[i][k] = sat_q8(longint'(pos_q8[i][k]) +
                            ((longint'(vel_q8[i][k]) * longint'(dt)) >>> 12));
    if (pos_q8[i][1] < -128000) begin
      life_q12[i] = 0;
      return;
    end
    if (tot_q12[i] == 0) return;
    lf = life_q12[i];
    tt = tot_q12[i];
    el = (lf <= tt) ? tt - lf : 0;
    if (lf > tt) lf = tt;
    size_cur[i] = int'((size_cur[i] * lf + size_end[i] * el) / tt);
    rgba[i][0] = int'((rgba[i][0] * lf + rgba[i][4] * el) / tt);
    rgba[i][1] = int'((rgba[i][1] * lf + rgba[i][5] * el) / tt);
    rgba[i][2] = int'((rgba[i][2] * lf) / tt);
    rgba[i][3] = int'((rgba[i][3] * lf * alpha_reg) / (tt * 256));
  endfunction

  function automatic ppu_pkg::ppu_out_t pool_step(ppu_pkg::ppu_in_t it);
    ppu_pkg::ppu_out_t r;
    int unsigned dt;
    int unsigned n;
    r = '0;
    case (it.mode)
      ppu_pkg::MODE_SPAWN: begin
        if (live_n < limit_reg) begin
          for (int i = 0; i < POOL; i++) begin
            if (life_q12[i] == 0) begin
              pos_q8[i] = '{int'(it.pos_x), int'(it.pos_y), int'(it.pos_z)};
              vel_q8[i] = '{int'(it.vel_x), int'(it.vel_y), int'(it.vel_z)};
              life_q12[i] = it.lifetime;
              tot_q12[i] = it.lifetime;
              size_cur[i] = it.start_size;
              size_end[i] = it.start_size / 5;
              rgba[i][0] = it.colour[31:24];
              rgba[i][1] = it.colour[23:16];
              rgba[i][2] = it.colour[15:8];
              rgba[i][3] = it.colour[7:0];
              rgba[i][4] = it.colour[31:24];
              rgba[i][5] = it.colour[23:16] / 2;
              live_n++;
              r.accepted = 1'b1;
              r.slot_used = 8'(i);
              break;
            end
          end
        end
      end
      ppu_pkg::MODE_TICK: begin
        dt = (it.time_step > ppu_pkg::DT_MAX) ? ppu_pkg::DT_MAX : it.time_step;
        n = 0;
        for (int i = 0; i < POOL; i++) begin
          if (life_q12[i] != 0) begin
            age_particle(i, dt);
            n++;
          end
        end
        live_n = n;
      end
      ppu_pkg::MODE_KILL1: begin
        if (it.slot < POOL) life_q12[it.slot] = 0;
      end
      default: begin
        for (int i = 0; i < POOL; i++) life_q12[i] = 0;
        live_n = 0;
      end
    endcase
    r.active_count = 9'(live_n);
    return r;
  endfunction

  // Accept items, predict, and check results
  always @(posedge clk_i) begin
    ppu_pkg::ppu_out_t want;
    ppu_pkg::ppu_out_t pred;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        pred = pool_step(in_data_i);
        n_items++;
        if (in_data_i.mode == ppu_pkg::MODE_TICK) n_ticks++;
        if (in_data_i.mode == ppu_pkg::MODE_SPAWN) begin
          if (pred.accepted) n_spawned++;
          else n_refused++;
        end
        if (typed_q.size() != 0 && typed_q.pop_front())
          pending_res.push_back(typed_res_q.pop_front());
        else pending_res.push_back(pred);
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_res.size() == 0) begin
          $error("result with no item outstanding: %p", out_data_o);
          errors++;
        end else begin
          want = pending_res.pop_front();
          if (out_data_o.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_data_o.accepted);
            errors++;
          end
          if (out_data_o.slot_used !== want.slot_used) begin
            $error("slot_used: expected %0d, got %0d", want.slot_used, out_data_o.slot_used);
            errors++;
          end
          if (out_data_o.active_count !== want.active_count) begin
            $error("active_count: expected %0d, got %0d", want.active_count,
                   out_data_o.active_count);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: alternate smooth stretches with random stalls
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) rx_smooth <= ~rx_smooth;
    out_ready_i <= rx_smooth ? 1'b1 : ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("particle_pool_update_top_tb: errors");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_item(ppu_pkg::ppu_in_t it, bit typed, ppu_pkg::ppu_out_t res);
    typed_q.push_back(typed);
    if (typed) typed_res_q.push_back(res);
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (POOL + 40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    if (idx == ppu_pkg::CFG_LIMIT)
      limit_reg = (val > POOL) ? POOL
                : ((val < ppu_pkg::LIMIT_MIN) ? ppu_pkg::LIMIT_MIN : val);
    else alpha_reg = (val > ppu_pkg::ALPHA_ONE) ? ppu_pkg::ALPHA_ONE : val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [23:0] rand_q8(bit wide);
    if (wide || $urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'(int'($urandom_range(0, 40000)) - 20000);
  endfunction

  function automatic ppu_pkg::ppu_in_t rand_item(int unsigned spawn_pct);
    ppu_pkg::ppu_in_t it;
    int unsigned pick;
    it = ppu_pkg::ppu_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom});
    pick = $urandom_range(0, 99);
    if (pick < spawn_pct) it.mode = ppu_pkg::MODE_SPAWN;
    else if (pick < spawn_pct + (100 - spawn_pct) * 6 / 10) it.mode = ppu_pkg::MODE_TICK;
    else if (pick < 97) it.mode = ppu_pkg::MODE_KILL1;
    else it.mode = ppu_pkg::MODE_KALL;
    if ($urandom_range(0, 4) != 0) begin
      // well-formed particle that stays above the floor for a while
      it.pos_x = rand_q8(0);
      it.pos_y = 24'(int'($urandom_range(0, 200000)) - 20000);
      it.pos_z = rand_q8(0);
      it.vel_x = rand_q8(0);
      it.vel_y = rand_q8(0);
      it.vel_z = rand_q8(0);
      it.lifetime = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 8000));
      it.time_step = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 205));
    end
    return it;
  endfunction

  task automatic run_random(int count, int unsigned spawn_pct);
    for (int k = 0; k < count; k++) send_item(rand_item(spawn_pct), 1'b0, '0);
  endtask

  dir_row_t dir_tab[$];

  function automatic ppu_pkg::ppu_in_t mk(logic [1:0] m, logic signed [23:0] py,
                                          logic signed [23:0] vy, logic [15:0] lf,
                                          logic [15:0] dt, logic [7:0] sl);
    ppu_pkg::ppu_in_t it;
    it = '0;
    it.mode = m;
    it.pos_y = py;
    it.vel_y = vy;
    it.lifetime = lf;
    it.start_size = 16'hFFFF;
    it.colour = 32'hFFFF_FFFF;
    it.time_step = dt;
    it.slot = sl;
    return it;
  endfunction

  initial begin
    ppu_pkg::ppu_in_t ext;
    pool_clear();
    ext = '{mode: ppu_pkg::MODE_SPAWN, pos_x: 24'sh7FFFFF, pos_y: 24'sh7FFFFF,
            pos_z: 24'sh800000, vel_x: 24'sh800000, vel_y: 24'sh7FFFFF, vel_z: 24'sh7FFFFF,
            lifetime: 16'hFFFF, start_size: 16'h0000, colour: 32'h0000_0000,
            time_step: 16'hFFFF, slot: 8'hFF};
    dir_tab.push_back('{mk(ppu_pkg::MODE_SPAWN, 0, 0, 16'd4096, 0, 0), 1'b1,
                        '{1'b1, 8'd0, 9'd1}});
    dir_tab.push_back('{ext, 1'b1, '{1'b1, 8'd1, 9'd2}});
    // zero lifetime: counted but the slot stays free
    dir_tab.push_back('{mk(ppu_pkg::MODE_SPAWN, 0, 0, 16'd0, 0, 0), 1'b1,
                        '{1'b1, 8'd2, 9'd3}});
    dir_tab.push_back('{mk(ppu_pkg::MODE_SPAWN, 1000, -5000, 16'd300, 0, 0), 1'b1,
                        '{1'b1, 8'd2, 9'd4}});
    dir_tab.push_back('{mk(ppu_pkg::MODE_TICK, 0, 0, 0, 16'd0, 0), 1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_TICK, 0, 0, 0, 16'hFFFF, 0), 1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_KILL1, 0, 0, 0, 0, 8'd0), 1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_KILL1, 0, 0, 0, 0, 8'd255), 1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_TICK, 0, 0, 0, 16'd205, 0), 1'b0, '0});
    // falls through the floor on the next tick
    dir_tab.push_back('{mk(ppu_pkg::MODE_SPAWN, -127990, 24'sh800000, 16'd5000, 0, 0),
                        1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_TICK, 0, 0, 0, 16'd100, 0), 1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_TICK, 0, 0, 0, 16'd204, 0), 1'b0, '0});
    dir_tab.push_back('{mk(ppu_pkg::MODE_KALL, 0, 0, 0, 0, 0), 1'b1, '{1'b0, 8'd0, 9'd0}});
    dir_tab.push_back('{mk(ppu_pkg::MODE_TICK, 0, 0, 0, 16'd50, 0), 1'b1,
                        '{1'b0, 8'd0, 9'd0}});
    dir_tab.push_back('{mk(ppu_pkg::MODE_KILL1, 0, 0, 0, 0, 8'd7), 1'b1,
                        '{1'b0, 8'd0, 9'd0}});
    dir_tab.push_back('{mk(ppu_pkg::MODE_SPAWN, 0, 0, 16'd1, 0, 0), 1'b1,
                        '{1'b1, 8'd0, 9'd1}});

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    drain();

    // limit at its floor, alpha off: refusals once the pool fills
    write_reg(ppu_pkg::CFG_LIMIT, 9'd10);
    write_reg(ppu_pkg::CFG_ALPHA, 9'd0);
    run_random(130, 75);
    drain();

    write_reg(ppu_pkg::CFG_LIMIT, 9'd100);
    write_reg(ppu_pkg::CFG_ALPHA, 9'd128);
    run_random(140, 55);
    drain();

    // oversize writes clamp to the top
    write_reg(ppu_pkg::CFG_LIMIT, 9'h1FF);
    write_reg(ppu_pkg::CFG_ALPHA, 9'h1FF);
    send_item(mk(ppu_pkg::MODE_KALL, 0, 0, 0, 0, 0), 1'b1, '{1'b0, 8'd0, 9'd0});
    run_random(140, 50);
    drain();

    write_reg(ppu_pkg::CFG_LIMIT, 9'd64);
    write_reg(ppu_pkg::CFG_ALPHA, 9'd256);
    run_random(130, 60);
    drain();

    $display("covered %0d items, %0d results: %0d spawns placed, %0d refused, %0d ticks",
             n_items, n_results, n_spawned, n_refused, n_ticks);
    $display("limits 64/100/256 and alpha 0/128/256 exercised");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("particle_pool_update_top_tb: clean");
    end else begin
      $display("particle_pool_update_top_tb: errors");
    end
    $finish;
  end

endmodule
